>>> hdl/oact_pkg.sv
// Package with the shared types, codes and constants of the occupancy aging cell table.
package oact_pkg;

    localparam int DEFAULT_NUM_ENTRIES = 32;
    localparam int KEY_W   = 32;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 16;
    localparam int OP_W    = 3;
    localparam int MODE_W  = 2;

    localparam logic [OP_W-1:0] OP_ENTER = 3'd0;
    localparam logic [OP_W-1:0] OP_LEAVE = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAIN = 3'd4;

    localparam logic [MODE_W-1:0] MODE_LOADED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACTIVE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVAL = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic CFG_IDLE_TIMEOUT   = 1'b0;
    localparam logic CFG_UNLOAD_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } ctrl_state_t;

    // Contents of one cell as seen on the shared read bus.
    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [COUNT_W-1:0]  count;
        logic [MODE_W-1:0]   mode;
        logic [TIME_W-1:0]   since;
        logic                since_set;
    } view_t;

    // Entry write broadcast from the controller.
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [COUNT_W-1:0]  count;
        logic [MODE_W-1:0]   mode;
        logic [TIME_W-1:0]   since;
        logic                since_set;
    } upd_t;

    // Walk controls shared by every cell.
    typedef struct packed {
        logic adv;
        logic tick_en;
        logic drain_en;
    } walk_ctl_t;

    // One result item.
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [MODE_W-1:0]   state;
        logic [COUNT_W-1:0]  count;
        logic                found;
        logic                full;
        logic                last;
    } res_t;

endpackage

>>> hdl/occupancy_aging_cell_table_unit.sv
// Top level of the occupancy aging cell table: stream ports, timeout registers and the cell row.
//
// The table is a row of NUM_ENTRIES cells, each holding one keyed entry with its
// occupant count, its mode (Loaded, Active, Idle, Removal) and the time it became
// empty. An item with a known opcode passes a token from cell to cell, one cell per cycle
// while the walk is not paused: the item is accepted, the token walks all NUM_ENTRIES
// cells, then a write-back and result step follows; an unknown opcode skips the walk and
// gets one result with tlast set. Enter, leave and query look up the key during the walk;
// enter and leave update the matching cell at the end, enter the first free cell on a miss;
// tick ages each empty cell as the token passes it; drain frees each Removal cell as the
// token passes and sends one result item for it, in ascending entry order, with tlast on
// the final one. A drain walk pauses while the output register is still occupied, so
// output backpressure stretches it. Only one item is in the table at a time; the result
// register lets the next item be accepted while the last result still waits downstream.
// The timeout registers must be written through the configuration port only while no
// item is in flight; the block itself does not enforce this.
module occupancy_aging_cell_table_unit #(
    parameter int NUM_ENTRIES = oact_pkg::DEFAULT_NUM_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,       // register index: 0 idle_timeout, 1 unload_timeout
    input  logic [31:0] cfg_data,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // opcode [2:0], cell_key [34:3], now_time [66:35]
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_key [31:0], cell_state [33:32],
                                        // occupant_count [49:34], entry_found [50],
                                        // table_full [51]
    output logic        m_axis_tlast    // last_result
);
    import oact_pkg::*;

    logic [TIME_W-1:0]      idle_to_reg, idle_to_next;
    logic [TIME_W-1:0]      unload_to_reg, unload_to_next;

    logic [NUM_ENTRIES:0]   tok;
    view_t                  views [NUM_ENTRIES];
    view_t                  view_bus;
    walk_ctl_t              ctl;
    logic [TIME_W-1:0]      now;
    logic [NUM_ENTRIES-1:0] upd_sel;
    upd_t                   upd;
    res_t                   res;
    logic                   start;

    // Configuration registers; the port is always ready.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        idle_to_next   = idle_to_reg;
        unload_to_next = unload_to_reg;
        if (cfg_valid)
        begin
            case (cfg_addr)
                CFG_IDLE_TIMEOUT:   idle_to_next   = cfg_data;
                CFG_UNLOAD_TIMEOUT: unload_to_next = cfg_data;
                default:            idle_to_next   = idle_to_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_to_reg   <= '0;
            unload_to_reg <= '0;
        end
        else
        begin
            idle_to_reg   <= idle_to_next;
            unload_to_reg <= unload_to_next;
        end
    end

    oact_ctrl #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tdata[2:0]),
        .in_key    (s_axis_tdata[34:3]),
        .in_now    (s_axis_tdata[66:35]),
        .view      (view_bus),
        .start     (start),
        .ctl       (ctl),
        .now       (now),
        .upd_sel   (upd_sel),
        .upd       (upd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // The token enters at cell 0 and moves one cell per advancing cycle.
    assign tok[0] = start;

    for (genvar g = 0; g < NUM_ENTRIES; g++)
    begin : g_cell
        oact_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .tok_in         (tok[g]),
            .ctl            (ctl),
            .now            (now),
            .idle_timeout   (idle_to_reg),
            .unload_timeout (unload_to_reg),
            .upd_we         (upd_sel[g]),
            .upd            (upd),
            .tok_out        (tok[g+1]),
            .view           (views[g])
        );
    end

    // Only the cell holding the token drives a nonzero view, so an OR merges them.
    always_comb
    begin
        view_bus = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            view_bus = view_bus | views[i];
        end
    end

    assign m_axis_tdata = {4'b0000, res.full, res.found, res.count, res.state, res.key};
    assign m_axis_tlast = res.last;

endmodule

>>> hdl/oact_cell.sv
// One table cell: holds one entry, ages it on tick, frees it on drain, passes the token on.
module oact_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tok_in,
    input  oact_pkg::walk_ctl_t         ctl,
    input  logic [oact_pkg::TIME_W-1:0] now,
    input  logic [oact_pkg::TIME_W-1:0] idle_timeout,
    input  logic [oact_pkg::TIME_W-1:0] unload_timeout,
    input  logic                        upd_we,
    input  oact_pkg::upd_t              upd,
    output logic                        tok_out,
    output oact_pkg::view_t             view
);
    import oact_pkg::*;

    logic                tok_reg, tok_next;
    logic                valid_reg, valid_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [TIME_W-1:0]   since_reg, since_next;
    logic                set_reg, set_next;
    logic [TIME_W-1:0]   elapsed;
    logic                act;

    assign elapsed = now - since_reg;
    assign act     = tok_reg && ctl.adv;

    always_comb
    begin
        tok_next   = ctl.adv ? tok_in : tok_reg;
        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        mode_next  = mode_reg;
        since_next = since_reg;
        set_next   = set_reg;
        if (upd_we)
        begin
            valid_next = 1'b1;
            key_next   = upd.key;
            count_next = upd.count;
            mode_next  = upd.mode;
            since_next = upd.since;
            set_next   = upd.since_set;
        end
        else if (act && ctl.tick_en && valid_reg && count_reg == '0)
        begin
            if (!set_reg)
            begin
                since_next = now;
                set_next   = 1'b1;
            end
            else if (elapsed >= unload_timeout)
            begin
                mode_next = MODE_REMOVAL;
            end
            else if (elapsed >= idle_timeout && mode_reg == MODE_LOADED)
            begin
                mode_next = MODE_IDLE;
            end
        end
        else if (act && ctl.drain_en && valid_reg && mode_reg == MODE_REMOVAL)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg   <= tok_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
        mode_reg  <= mode_next;
        since_reg <= since_next;
        set_reg   <= set_next;
    end

    assign tok_out = tok_reg;

    always_comb
    begin
        view = '0;
        if (tok_reg)
        begin
            view.valid     = valid_reg;
            view.key       = key_reg;
            view.count     = count_reg;
            view.mode      = mode_reg;
            view.since     = since_reg;
            view.since_set = set_reg;
        end
    end

endmodule

>>> hdl/oact_ctrl.sv
// Sequencer: accepts an item, walks the token down the cell row, writes back and emits results.
module oact_ctrl #(
    parameter int NUM_ENTRIES = oact_pkg::DEFAULT_NUM_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [oact_pkg::OP_W-1:0]   in_op,
    input  logic [oact_pkg::KEY_W-1:0]  in_key,
    input  logic [oact_pkg::TIME_W-1:0] in_now,
    input  oact_pkg::view_t             view,
    output logic                        start,
    output oact_pkg::walk_ctl_t         ctl,
    output logic [oact_pkg::TIME_W-1:0] now,
    output logic [NUM_ENTRIES-1:0]      upd_sel,
    output oact_pkg::upd_t              upd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output oact_pkg::res_t              out_res
);
    import oact_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam logic [IW-1:0] LAST_POS = IW'(NUM_ENTRIES - 1);

    ctrl_state_t        st_reg, st_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [IW-1:0]      pos_reg, pos_next;
    logic               hit_reg, hit_next;
    logic [IW-1:0]      hit_idx_reg, hit_idx_next;
    view_t              hit_view_reg, hit_view_next;
    logic               free_reg, free_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic               hold_valid_reg, hold_valid_next;
    res_t               hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;

    logic               out_free;
    logic               rem;
    logic               upd_we;
    logic [IW-1:0]      upd_idx;
    logic [COUNT_W-1:0] new_count;
    logic [MODE_W-1:0]  new_mode;

    assign out_free = !out_valid_reg || out_ready;
    assign rem      = op_reg == OP_DRAIN && view.valid && view.mode == MODE_REMOVAL;
    assign now      = now_reg;

    always_comb
    begin
        st_next         = st_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        pos_next        = pos_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_view_next   = hit_view_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        in_ready        = 1'b0;
        start           = 1'b0;
        ctl             = '0;
        upd_we          = 1'b0;
        upd_idx         = hit_idx_reg;
        upd             = '0;
        new_count       = '0;
        new_mode        = MODE_LOADED;

        case (st_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next         = in_op;
                    key_next        = in_key;
                    now_next        = in_now;
                    pos_next        = '0;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    hold_valid_next = 1'b0;
                    if (in_op inside {OP_ENTER, OP_LEAVE, OP_TICK, OP_QUERY, OP_DRAIN})
                    begin
                        start   = 1'b1;
                        ctl.adv = 1'b1;
                        st_next = ST_WALK;
                    end
                    else
                    begin
                        st_next = ST_DONE;
                    end
                end
            end

            ST_WALK:
            begin
                ctl.tick_en  = op_reg == OP_TICK;
                ctl.drain_en = op_reg == OP_DRAIN;
                ctl.adv      = !(rem && hold_valid_reg && !out_free);
                if (ctl.adv)
                begin
                    if (view.valid && view.key == key_reg && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = pos_reg;
                        hit_view_next = view;
                    end
                    if (!view.valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = pos_reg;
                    end
                    if (rem)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = hold_reg;
                        end
                        hold_valid_next = 1'b1;
                        hold_next       = '{key: view.key, state: MODE_REMOVAL,
                                            count: view.count, found: 1'b1,
                                            full: 1'b0, last: 1'b0};
                    end
                    if (pos_reg == LAST_POS)
                    begin
                        st_next = ST_DONE;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.last  = 1'b1;
                    st_next        = ST_IDLE;
                    case (op_reg)
                        OP_ENTER:
                        begin
                            out_next.key = key_reg;
                            if (hit_reg)
                            begin
                                new_count = (hit_view_reg.count == COUNT_MAX) ?
                                            hit_view_reg.count : hit_view_reg.count + 1'b1;
                                upd_we  = 1'b1;
                                upd_idx = hit_idx_reg;
                                upd     = '{key: key_reg, count: new_count, mode: MODE_ACTIVE,
                                            since: hit_view_reg.since, since_set: 1'b0};
                                out_next.state = MODE_ACTIVE;
                                out_next.count = new_count;
                                out_next.found = 1'b1;
                            end
                            else if (free_reg)
                            begin
                                upd_we  = 1'b1;
                                upd_idx = free_idx_reg;
                                upd     = '{key: key_reg, count: COUNT_W'(1), mode: MODE_ACTIVE,
                                            since: '0, since_set: 1'b0};
                                out_next.state = MODE_ACTIVE;
                                out_next.count = COUNT_W'(1);
                                out_next.found = 1'b1;
                            end
                            else
                            begin
                                out_next.full = 1'b1;
                            end
                        end
                        OP_LEAVE:
                        begin
                            out_next.key = key_reg;
                            if (hit_reg)
                            begin
                                new_count = (hit_view_reg.count != '0) ?
                                            hit_view_reg.count - 1'b1 : '0;
                                new_mode  = hit_view_reg.mode;
                                upd       = '{key: key_reg, count: new_count,
                                              mode: hit_view_reg.mode,
                                              since: hit_view_reg.since,
                                              since_set: hit_view_reg.since_set};
                                if (new_count == '0)
                                begin
                                    if (hit_view_reg.mode == MODE_ACTIVE)
                                    begin
                                        new_mode = MODE_LOADED;
                                    end
                                    if (!hit_view_reg.since_set)
                                    begin
                                        upd.since     = now_reg;
                                        upd.since_set = 1'b1;
                                    end
                                end
                                upd.mode       = new_mode;
                                upd_we         = 1'b1;
                                upd_idx        = hit_idx_reg;
                                out_next.state = new_mode;
                                out_next.count = new_count;
                                out_next.found = 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            out_next.key = key_reg;
                            if (hit_reg)
                            begin
                                out_next.state = hit_view_reg.mode;
                                out_next.count = hit_view_reg.count;
                                out_next.found = 1'b1;
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (hold_valid_reg)
                            begin
                                out_next      = hold_reg;
                                out_next.last = 1'b1;
                            end
                            hold_valid_next = 1'b0;
                        end
                        default:
                        begin
                            out_next.last = 1'b1;
                        end
                    endcase
                end
            end

            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            upd_sel[i] = upd_we && upd_idx == IW'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            st_reg         <= st_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        now_reg      <= now_next;
        hit_idx_reg  <= hit_idx_next;
        hit_view_reg <= hit_view_next;
        free_idx_reg <= free_idx_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule
